// File: rtl/point_light_table_shader_top_assert.svh
// Assertion macros for the point light table shader checker.
`ifndef POINT_LIGHT_TABLE_SHADER_TOP_ASSERT_SVH
`define POINT_LIGHT_TABLE_SHADER_TOP_ASSERT_SVH
// Property that holds at every edge once out of reset.
`define PLTS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("lbl failed");
// Implication on the next edge.
`define PLTS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("lbl failed");
`endif

// File: rtl/plts_pkg.sv
// Package: constants, command codes and shared types of the light table shader.
package plts_pkg;
  localparam int LIGHT_SLOTS = 32;
  localparam int IDX_W = $clog2(LIGHT_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int QDEPTH = 2;
  localparam logic [15:0] AMBIENT_Q8 = 16'd26;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_CLEAR = 3'd2, CMD_UPDATE = 3'd3, CMD_SHADE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_BAD_INDEX = 2'd2
  } status_t;

  // entry record: origin, color, intensity, radius
  localparam int ENT_W = 3 * 24 + 3 * 16 + 16 + 24;

  // front classification of one command
  typedef struct packed {
    logic                shade;   // needs the back end's light walk
    logic [1:0]          status;
    logic [IDX_W-1:0]    assigned;
    logic [CNT_W-1:0]    total;
    logic signed [23:0]  px, py, pz;
    logic signed [15:0]  nx, ny, nz;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_GEOM, BK_SQRT, BK_DIV1, BK_DIV2, BK_MUL, BK_DONE
  } bk_state_t;
endpackage

// File: rtl/plts_ram.sv
// Generic single-port-write, registered-read RAM.
module plts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/plts_front.sv
// Front end: takes commands, keeps the table count, writes the light table.
module plts_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   command,
  input  logic [4:0]                   light_index,
  input  logic signed [23:0]           pos_x, pos_y, pos_z,
  input  logic signed [15:0]           vec_x, vec_y, vec_z,
  input  logic [15:0]                  intensity,
  input  logic [23:0]                  radius,
  input  logic                         q_full,
  input  logic                         q_empty,
  output logic                         q_push,
  output plts_pkg::job_t               q_data,
  input  logic                         back_idle,
  output logic [plts_pkg::CNT_W-1:0]   count,
  output logic                         we,
  output logic [plts_pkg::IDX_W-1:0]   waddr,
  output logic [plts_pkg::ENT_W-1:0]   wdata,
  output logic [plts_pkg::IDX_W-1:0]   mv_raddr,
  input  logic [plts_pkg::ENT_W-1:0]   mv_rdata
);
  logic                       mv_pend, mv_wait;
  logic [plts_pkg::IDX_W-1:0] mv_dst;
  logic [plts_pkg::CNT_W-1:0] count_next;
  logic                       acc;
  logic                       idx_ok;
  logic                       tbl_wr;
  plts_pkg::cmd_t             cmd;

  assign cmd    = plts_pkg::cmd_t'(command);
  // commands that write the table wait until the queue is empty and the back end idle,
  // so a shade sees the table as it stood when it was accepted
  assign tbl_wr = (cmd == plts_pkg::CMD_ADD) | (cmd == plts_pkg::CMD_REMOVE) |
                  (cmd == plts_pkg::CMD_UPDATE);
  assign busy   = q_full | mv_pend | mv_wait | (tbl_wr & ~(back_idle & q_empty));
  assign acc    = start & ~busy;
  assign idx_ok = {1'b0, light_index} < count;
  assign mv_raddr = plts_pkg::IDX_W'(count);

  always_comb begin
    q_data = '0;
    q_data.px = pos_x; q_data.py = pos_y; q_data.pz = pos_z;
    q_data.nx = vec_x; q_data.ny = vec_y; q_data.nz = vec_z;
    q_data.status = plts_pkg::ST_OK;
    count_next = count;
    we = 1'b0;
    waddr = light_index;
    wdata = {pos_x, pos_y, pos_z, vec_x, vec_y, vec_z, intensity, radius};
    case (cmd)
      plts_pkg::CMD_ADD: begin
        if (count >= plts_pkg::CNT_W'(plts_pkg::LIGHT_SLOTS)) begin
          q_data.status = plts_pkg::ST_FULL;
        end else begin
          we = acc;
          waddr = plts_pkg::IDX_W'(count);
          q_data.assigned = plts_pkg::IDX_W'(count);
          count_next = count + 1'b1;
        end
      end
      plts_pkg::CMD_REMOVE: begin
        if (!idx_ok) q_data.status = plts_pkg::ST_BAD_INDEX;
        else count_next = count - 1'b1;
      end
      plts_pkg::CMD_CLEAR: count_next = '0;
      plts_pkg::CMD_UPDATE: begin
        if (!idx_ok) q_data.status = plts_pkg::ST_BAD_INDEX;
        else we = acc;
      end
      plts_pkg::CMD_SHADE: q_data.shade = 1'b1;
      default: ;
    endcase
    q_data.total = count_next;
    q_push = acc;
    if (mv_wait) begin
      we = 1'b1;
      waddr = mv_dst;
      wdata = mv_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mv_pend <= 1'b0;
      mv_wait <= 1'b0;
    end else begin
      mv_wait <= mv_pend;
      mv_pend <= 1'b0;
      if (acc) begin
        count <= count_next;
        if (cmd == plts_pkg::CMD_REMOVE && idx_ok) begin
          mv_pend <= 1'b1;
          mv_dst <= light_index;
        end
      end
    end
  end
endmodule

// File: rtl/plts_queue.sv
// Short FIFO of classified commands between front and back ends.
module plts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  plts_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output plts_pkg::job_t dout
);
  localparam int AW = $clog2(plts_pkg::QDEPTH);
  plts_pkg::job_t slots [plts_pkg::QDEPTH];
  logic [AW-1:0]  rp, wp;
  logic [AW:0]    fill;

  assign full  = fill == (AW+1)'(plts_pkg::QDEPTH);
  assign empty = fill == '0;
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wp] <= din;
    if (rst) begin
      rp <= '0; wp <= '0; fill <= '0;
    end else begin
      if (push && !full) wp <= wp + 1'b1;
      if (pop && !empty) rp <= rp + 1'b1;
      fill <= fill + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

// File: rtl/plts_back.sv
// Back end: walks the lights for a shade, issues one result per command.
module plts_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  plts_pkg::job_t              q_data,
  output logic                        q_pop,
  output logic                        idle,
  output logic [plts_pkg::IDX_W-1:0]  raddr,
  input  logic [plts_pkg::ENT_W-1:0]  rdata,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [4:0]                  assigned_index,
  output logic [5:0]                  light_total,
  output logic [15:0]                 lit_red,
  output logic [15:0]                 lit_green,
  output logic [15:0]                 lit_blue
);
  plts_pkg::bk_state_t state, state_next;
  plts_pkg::job_t      job;
  logic [plts_pkg::CNT_W-1:0] li;
  logic signed [26:0]  acc_r, acc_g, acc_b;
  // geometry
  logic signed [24:0]  dx, dy, dz;
  logic signed [49:0]  sx, sy, sz;
  logic signed [43:0]  ex, ey, ez;
  logic [49:0]         sq;
  logic signed [43:0]  dot;
  logic signed [15:0]  cr, cg, cb;
  logic [15:0]         inten;
  logic [23:0]         rad;
  // sqrt
  logic [49:0]         s_rem;
  logic [24:0]         s_root;
  logic [4:0]          s_cnt;
  // divider (shared, restoring, one bit per cycle)
  logic [43:0]         dv_rem, dv_quo;
  logic [24:0]         dv_den;
  logic [5:0]          dv_cnt;
  logic [43:0]         dv_num;
  logic [16:0]         diff;
  logic [15:0]         att;
  logic [15:0]         att2;
  logic [16:0]         w;
  logic [1:0]          mstep;
  logic [32:0]         ciw;
  logic [44:0]         dtrial;
  logic                skip;
  logic [15:0]         mr, mg, mb;
  logic signed [26:0]  add_r, add_g, add_b;
  logic [47:0]         pr, pg, pb;

  assign raddr = li[plts_pkg::IDX_W-1:0];
  assign idle  = state == plts_pkg::BK_IDLE;

  function automatic logic [15:0] sat(input logic signed [26:0] v);
    if (v < 0) sat = '0;
    else if (v > 27'sd65535) sat = 16'hFFFF;
    else sat = v[15:0];
  endfunction

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    case (state)
      plts_pkg::BK_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        state_next = (q_data.shade && q_data.total != '0) ? plts_pkg::BK_READ
                                                          : plts_pkg::BK_DONE;
      end
      plts_pkg::BK_READ: state_next = plts_pkg::BK_GEOM;
      plts_pkg::BK_GEOM: state_next = plts_pkg::BK_SQRT;
      plts_pkg::BK_SQRT: if (s_cnt == '0) state_next = plts_pkg::BK_DIV1;
      plts_pkg::BK_DIV1: if (skip) state_next = plts_pkg::BK_MUL;
        else if (dv_cnt == '0) state_next = plts_pkg::BK_DIV2;
      plts_pkg::BK_DIV2: if (dv_cnt == '0) state_next = plts_pkg::BK_MUL;
      plts_pkg::BK_MUL: if (mstep == 2'd3) state_next =
        (li + 1'b1 >= job.total) ? plts_pkg::BK_DONE : plts_pkg::BK_READ;
      plts_pkg::BK_DONE: state_next = plts_pkg::BK_IDLE;
      default: state_next = plts_pkg::BK_IDLE;
    endcase
  end

  // offset to the light and its squares and normal products, full width
  assign dx = 25'($signed(rdata[159:136])) - 25'(job.px);
  assign dy = 25'($signed(rdata[135:112])) - 25'(job.py);
  assign dz = 25'($signed(rdata[111:88])) - 25'(job.pz);
  assign sx = dx * dx;
  assign sy = dy * dy;
  assign sz = dz * dz;
  assign ex = dx * job.nx;
  assign ey = dy * job.ny;
  assign ez = dz * job.nz;

  assign dtrial = {dv_rem[42:0], dv_num[43]} - {20'd0, dv_den};
  assign mr = cr[15] ? $unsigned(-cr) : $unsigned(cr);
  assign mg = cg[15] ? $unsigned(-cg) : $unsigned(cg);
  assign mb = cb[15] ? $unsigned(-cb) : $unsigned(cb);
  assign pr = 48'(mr) * 48'(ciw);
  assign pg = 48'(mg) * 48'(ciw);
  assign pb = 48'(mb) * 48'(ciw);
  assign add_r = cr < 0 ? -27'(pr >> 28) : 27'(pr >> 28);
  assign add_g = cg < 0 ? -27'(pg >> 28) : 27'(pg >> 28);
  assign add_b = cb < 0 ? -27'(pb >> 28) : 27'(pb >> 28);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plts_pkg::BK_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        plts_pkg::BK_IDLE: if (!q_empty) begin
          job <= q_data;
          li <= '0;
          acc_r <= 27'(plts_pkg::AMBIENT_Q8);
          acc_g <= 27'(plts_pkg::AMBIENT_Q8);
          acc_b <= 27'(plts_pkg::AMBIENT_Q8);
        end
        plts_pkg::BK_READ: ;
        plts_pkg::BK_GEOM: begin
          sq <= $unsigned(sx) + $unsigned(sy) + $unsigned(sz);
          dot <= ex + ey + ez;
          cr <= rdata[87:72]; cg <= rdata[71:56]; cb <= rdata[55:40];
          inten <= rdata[39:24]; rad <= rdata[23:0];
          s_rem <= '0; s_root <= '0; s_cnt <= 5'd25;
        end
        plts_pkg::BK_SQRT: begin
          // one root bit per cycle
          if (s_cnt != '0) begin
            if ({s_rem[47:0], sq[49:48]} >= {23'd0, s_root, 2'b01}) begin
              s_rem <= {s_rem[47:0], sq[49:48]} - {23'd0, s_root, 2'b01};
              s_root <= {s_root[23:0], 1'b1};
            end else begin
              s_rem <= {s_rem[47:0], sq[49:48]};
              s_root <= {s_root[23:0], 1'b0};
            end
            sq <= {sq[47:0], 2'b00};
            s_cnt <= s_cnt - 1'b1;
          end else begin
            skip <= s_root == '0 || rad == '0 || s_root > {1'b0, rad} || dot <= 0;
            dv_num <= dot; dv_den <= s_root; dv_rem <= '0; dv_quo <= '0;
            dv_cnt <= 6'd44;
          end
        end
        plts_pkg::BK_DIV1, plts_pkg::BK_DIV2: if (!skip) begin
          if (dv_cnt != '0) begin
            if (!dtrial[44]) begin
              dv_rem <= dtrial[43:0];
              dv_quo <= {dv_quo[42:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[42:0], dv_num[43]};
              dv_quo <= {dv_quo[42:0], 1'b0};
            end
            dv_num <= {dv_num[42:0], 1'b0};
            dv_cnt <= dv_cnt - 1'b1;
          end else if (state == plts_pkg::BK_DIV1) begin
            // diff stays below 2^17: |n| < 2^16 raw and |d| / dist < 2
            diff <= dv_quo[16:0];
            dv_num <= {6'd0, 24'({1'b0, rad} - s_root), 14'd0};
            dv_den <= {1'b0, rad}; dv_rem <= '0; dv_quo <= '0;
            dv_cnt <= 6'd44;
          end else begin
            att <= dv_quo[15:0];
          end
          mstep <= '0;
        end else mstep <= '0;
        plts_pkg::BK_MUL: begin
          mstep <= mstep + 1'b1;
          case (mstep)
            2'd0: att2 <= 16'((32'(att) * 32'(att)) >> 14);
            2'd1: w <= 17'((34'(diff) * 34'(att2)) >> 14);
            2'd2: ciw <= 33'(inten) * 33'(w);
            default: begin
              if (!skip) begin
                acc_r <= acc_r + add_r; acc_g <= acc_g + add_g; acc_b <= acc_b + add_b;
              end
              li <= li + 1'b1;
            end
          endcase
        end
        plts_pkg::BK_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == plts_pkg::BK_DONE) begin
      status <= job.status;
      assigned_index <= 5'(job.assigned);
      light_total <= 6'(job.total);
      lit_red   <= job.shade ? sat(acc_r) : '0;
      lit_green <= job.shade ? sat(acc_g) : '0;
      lit_blue  <= job.shade ? sat(acc_b) : '0;
    end
  end
endmodule

// File: rtl/point_light_table_shader_top.sv
// Top level of the point light table shader.
//  channel  | handshake        | payload
//  command  | start / busy     | command, light_index, pos_*, vec_*, intensity, radius
//  result   | done (1 cycle)   | status, assigned_index, light_total, lit_*
// Table commands pass through the queue and the back end's done state to the result;
// remove adds a copy of the last entry into the freed slot before the next command is taken.
// Shade walks the N lights in turn: per light a table read, the 25 step root and two
// divides on the shared one-bit-per-cycle divider, plus 4 multiply steps; a light
// skipped after the root passes through BK_DIV1 without dividing and goes on to the multiply steps.
// rst is synchronous active high; it empties the table and the command queue.
// busy rises when the 2 entry queue is full, a remove copy is pending, or an add,
// remove or update arrives while the queue holds a command or the back end is not idle; done cannot be stalled.
module point_light_table_shader_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic [4:0]         light_index,
  input  logic signed [23:0] pos_x, pos_y, pos_z,
  input  logic signed [15:0] vec_x, vec_y, vec_z,
  input  logic [15:0]        intensity,
  input  logic [23:0]        radius,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         assigned_index,
  output logic [5:0]         light_total,
  output logic [15:0]        lit_red,
  output logic [15:0]        lit_green,
  output logic [15:0]        lit_blue
);
  plts_pkg::job_t qin, qout;
  logic q_full, q_empty, q_push, q_pop, back_idle;
  logic [plts_pkg::CNT_W-1:0] count;
  logic we;
  logic [plts_pkg::IDX_W-1:0] waddr, raddr, mv_raddr, bk_raddr;
  logic [plts_pkg::ENT_W-1:0] wdata, rdata;

  plts_front u_front (
    .clk, .rst, .start, .busy, .command, .light_index, .pos_x, .pos_y, .pos_z,
    .vec_x, .vec_y, .vec_z, .intensity, .radius, .q_full, .q_empty, .q_push,
    .q_data(qin), .back_idle, .count, .we, .waddr, .wdata, .mv_raddr, .mv_rdata(rdata)
  );

  plts_queue u_queue (
    .clk, .rst, .push(q_push), .din(qin), .full(q_full), .pop(q_pop),
    .empty(q_empty), .dout(qout)
  );

  // a remove copy owns the read port; table writes wait until the back end drains
  assign raddr = back_idle ? mv_raddr : bk_raddr;

  plts_ram #(.WIDTH(plts_pkg::ENT_W), .DEPTH(plts_pkg::LIGHT_SLOTS)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  plts_back u_back (
    .clk, .rst, .q_empty, .q_data(qout), .q_pop, .idle(back_idle), .raddr(bk_raddr),
    .rdata, .done, .status, .assigned_index, .light_total, .lit_red, .lit_green, .lit_blue
  );
endmodule

// File: rtl/plts_checker.sv
// Port-level checker for the point light table shader, bound to the top level.
`include "point_light_table_shader_top_assert.svh"
module plts_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic [1:0] status,
  input logic [5:0] light_total,
  input logic [15:0] lit_red
);
  `PLTS_ASSERT(a_status_code, !done || status <= plts_pkg::ST_BAD_INDEX)
  `PLTS_ASSERT(a_total_range, !done || light_total <= 6'd32)
  // only shades report a color, and they always report ok
  `PLTS_ASSERT(a_error_dark, !done || status == plts_pkg::ST_OK || lit_red == '0)
  `PLTS_NEXT(a_done_single, done, !done)
endmodule

bind point_light_table_shader_top plts_port_checker u_plts_checker (
  .clk, .rst, .done, .status, .light_total, .lit_red
);

// File: test/plts_checker.sv
// Result checker for the point light table shader: predicts each result and compares it.
module plts_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         command,
  input  logic [4:0]         light_index,
  input  logic signed [23:0] pos_x, pos_y, pos_z,
  input  logic signed [15:0] vec_x, vec_y, vec_z,
  input  logic [15:0]        intensity,
  input  logic [23:0]        radius,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic [4:0]         assigned_index,
  input  logic [5:0]         light_total,
  input  logic [15:0]        lit_red,
  input  logic [15:0]        lit_green,
  input  logic [15:0]        lit_blue,
  output int                 fail_count,
  output int                 pending,
  output int                 shade_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  assigned;
    logic [5:0]  total;
    logic [15:0] r, g, b;
  } reply_t;

  typedef struct {
    logic signed [23:0] org [3];
    logic signed [15:0] col [3];
    logic [15:0]        inten;
    logic [23:0]        rad;
  } lamp_t;

  lamp_t    lamps [plts_pkg::LIGHT_SLOTS];
  int       lamp_count;
  reply_t   replies [$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Lit color at one point; accumulates per light as the block does.
  task automatic shade_point(input logic signed [23:0] p [3],
                             input logic signed [15:0] n [3], inout reply_t rep);
    longint acc [3];
    longint d, dot;
    longint unsigned sq, span, rad, diff, att, att2, w, mag, prod;
    for (int k = 0; k < 3; k++) acc[k] = plts_pkg::AMBIENT_Q8;
    for (int i = 0; i < lamp_count; i++) begin
      sq = 0;
      dot = 0;
      rad = lamps[i].rad;
      for (int k = 0; k < 3; k++) begin
        d = longint'(lamps[i].org[k]) - longint'(p[k]);
        sq += longint'(d < 0 ? -d : d) * longint'(d < 0 ? -d : d);
        dot += longint'(n[k]) * d;
      end
      span = int_sqrt(sq);
      if (span == 0 || rad == 0 || span > rad || dot <= 0) continue;
      diff = longint'(dot) / span;
      att = ((rad - span) << 14) / rad;
      att2 = (att * att) >> 14;
      w = (diff * att2) >> 14;
      for (int k = 0; k < 3; k++) begin
        mag = lamps[i].col[k] < 0 ? -longint'(lamps[i].col[k]) : lamps[i].col[k];
        prod = (mag * lamps[i].inten * w) >> 28;
        acc[k] += lamps[i].col[k] < 0 ? -longint'(prod) : longint'(prod);
      end
    end
    rep.r = clamp16(acc[0]);
    rep.g = clamp16(acc[1]);
    rep.b = clamp16(acc[2]);
  endtask

  task automatic apply_command();
    reply_t rep;
    lamp_t  fresh;
    logic signed [23:0] p [3];
    logic signed [15:0] n [3];
    rep = '0;
    p = '{pos_x, pos_y, pos_z};
    n = '{vec_x, vec_y, vec_z};
    fresh.org = p;
    fresh.col = n;
    fresh.inten = intensity;
    fresh.rad = radius;
    case (command)
      plts_pkg::CMD_ADD: begin
        if (lamp_count >= plts_pkg::LIGHT_SLOTS) begin
          rep.status = plts_pkg::ST_FULL;
        end else begin
          lamps[lamp_count] = fresh;
          rep.assigned = 5'(lamp_count);
          lamp_count++;
        end
      end
      plts_pkg::CMD_REMOVE: begin
        if (light_index >= lamp_count) begin
          rep.status = plts_pkg::ST_BAD_INDEX;
        end else begin
          lamps[light_index] = lamps[lamp_count - 1];
          lamp_count--;
        end
      end
      plts_pkg::CMD_CLEAR: lamp_count = 0;
      plts_pkg::CMD_UPDATE: begin
        if (light_index >= lamp_count) rep.status = plts_pkg::ST_BAD_INDEX;
        else lamps[light_index] = fresh;
      end
      plts_pkg::CMD_SHADE: begin
        shade_point(p, n, rep);
        shade_count++;
      end
      default: ;
    endcase
    rep.total = 6'(lamp_count);
    replies.push_back(rep);
  endtask

  always @(posedge clk) begin
    reply_t want, got;
    if (rst) begin
      lamp_count = 0;
      replies.delete();
      fail_count = 0;
      shade_count = 0;
    end else begin
      // result first: a transfer accepted this edge is not visible yet
      if (done) begin
        got = '{status, assigned_index, light_total, lit_red, lit_green, lit_blue};
        if (replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = replies.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (start && !busy) apply_command();
    end
    pending = replies.size();
  end
endmodule

// File: test/tb_point_light_table_shader_top.sv
// Testbench top: stimulus, idling phases and verdict for the light table shader.
module tb_point_light_table_shader_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         command = '0;
  logic [4:0]         light_index = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic [15:0]        intensity = '0;
  logic [23:0]        radius = '0;
  logic               done;
  logic [1:0]         status;
  logic [4:0]         assigned_index;
  logic [5:0]         light_total;
  logic [15:0]        lit_red, lit_green, lit_blue;
  int                 fail_count, pending, shade_count;
  int                 idle_pct;     // chance in percent of a gap before a transfer
  int                 quiet_cycles; // cycles with no transfer on either side
  int                 sent;
  int                 lamps_held;   // testbench's own view of the table size

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_light_table_shader_top dut (.*);

  plts_checker chk (.*);

  // Watchdog: the limit covers the worst shade, which walks 32 lights.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One command transfer; holds start until accepted, gap chance by idle_pct.
  task automatic issue(input logic [2:0] cmd, input logic [4:0] idx,
                       input logic signed [23:0] px, py, pz,
                       input logic signed [15:0] vx, vy, vz,
                       input logic [15:0] inten, input logic [23:0] rad);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    light_index <= idx;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    intensity <= inten;
    radius <= rad;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    // keep the local table size in step for index choice
    case (cmd)
      plts_pkg::CMD_ADD:    if (lamps_held < plts_pkg::LIGHT_SLOTS) lamps_held++;
      plts_pkg::CMD_REMOVE: if (idx < lamps_held) lamps_held--;
      plts_pkg::CMD_CLEAR:  lamps_held = 0;
      default: ;
    endcase
  endtask

  // Lights clustered near the origin so that shading finds lights in range.
  task automatic random_item();
    int pick;
    logic [2:0] cmd;
    logic [4:0] idx;
    logic signed [23:0] p [3];
    logic signed [15:0] v [3];
    logic [23:0] rad;
    pick = $urandom_range(99);
    if (pick < 30) cmd = plts_pkg::CMD_ADD;
    else if (pick < 40) cmd = plts_pkg::CMD_REMOVE;
    else if (pick < 43) cmd = plts_pkg::CMD_CLEAR;
    else if (pick < 53) cmd = plts_pkg::CMD_UPDATE;
    else if (pick < 97) cmd = plts_pkg::CMD_SHADE;
    else cmd = 3'($urandom_range(7, 5));
    // shading cost grows with the table; keep it modest mostly
    if (cmd == plts_pkg::CMD_ADD && lamps_held > 8 && $urandom_range(9) != 0)
      cmd = plts_pkg::CMD_SHADE;
    if ($urandom_range(9) == 0 || lamps_held == 0) idx = 5'($urandom);
    else idx = 5'($urandom_range(lamps_held - 1));
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(9) == 0) p[k] = 24'($urandom);
      else p[k] = $signed(24'($urandom_range(8191))) - 24'sd4096;
      v[k] = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(32767));
    end
    if (cmd == plts_pkg::CMD_SHADE && $urandom_range(3) != 0)
      v[$urandom_range(2)] = 16'sd16384;
    rad = $urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(12000));
    issue(cmd, idx, p[0], p[1], p[2], v[0], v[1], v[2], 16'($urandom), rad);
  endtask

  initial begin
    idle_pct = 0;
    sent = 0;
    lamps_held = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table cases, extremes, bad indexes, full table
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    issue(plts_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(plts_pkg::CMD_UPDATE, 31, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(plts_pkg::CMD_ADD, 0, 1024, 0, 0, 16384, 16384, 16384, 16'hFFFF, 24'd4096);
    issue(plts_pkg::CMD_ADD, 0, -24'sd8388608, 24'sd8388607, 0, -16'sd32768, 16'sd32767,
          0, 16'h0100, 24'hFFFFFF);
    issue(plts_pkg::CMD_ADD, 0, 0, 0, 0, 16384, 16384, 16384, 16'h0100, 0); // zero radius
    issue(plts_pkg::CMD_ADD, 0, 0, 256, 0, -16'sd16384, 16384, 16384, 16'h0400, 24'd512);
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, 16384, 0, 0, 0, 0);          // zero distance
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, 16384, 16384, 16384, 0, 0);  // non-unit normal
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, -16'sd16384, 0, 0, 0, 0);    // facing away
    issue(plts_pkg::CMD_SHADE, 0, 24'sd8388607, 0, 0, -16'sd32768, 0, 0, 0, 0);
    issue(plts_pkg::CMD_UPDATE, 1, 512, 0, 0, 32767, 32767, 32767, 16'hFFFF, 24'd2048);
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    issue(plts_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(plts_pkg::CMD_REMOVE, 31, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(3'd7, 31, -1, -1, -1, -1, -1, -1, 16'hFFFF, 24'hFFFFFF);
    issue(plts_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 33; i++)
      issue(plts_pkg::CMD_ADD, 5'(i), 24'(i * 64), 0, 0, 16384, 8192, 4096, 16'h0100,
            24'd800);
    issue(plts_pkg::CMD_SHADE, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    issue(plts_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // random phases: none, sender idle, receiver note inapplicable, mixed
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = ph == 1 ? 87 : ph == 3 ? 26 : 0;
      repeat (187) random_item();
    end
    start <= 1'b0;
    idle_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d commands, %0d of them shades, through four idling phases.",
             sent, shade_count);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
